// File: rtl/core/lhb_pkg.sv
// ----------------------------------------------------------------------------
// lhb_pkg
// Shared constants, codes and types of the LED health bar renderer.
// ----------------------------------------------------------------------------
package lhb_pkg;

  localparam int GROUP_COUNT = 28;
  localparam int GRP_W       = $clog2(GROUP_COUNT + 1);

  localparam logic [16:0] FULL_Q16  = 17'h10000;
  localparam logic [31:0] TTL_MAX   = 32'h7fff_ffff;
  localparam logic [24:0] ROUND_Q16 = 25'h0_8000;

  // Item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_DIRTY = 2'd3;

  // Remote display modes
  localparam logic [2:0] MODE_ACTIVE = 3'd0;
  localparam logic [2:0] MODE_HIT    = 3'd1;
  localparam logic [2:0] MODE_STALE  = 3'd2;
  localparam logic [2:0] MODE_DOWN   = 3'd3;
  localparam logic [2:0] MODE_OFF    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLINK      = 2'd0;
  localparam logic [1:0] CFG_DOWN_BLINK = 2'd1;
  localparam logic [1:0] CFG_SHOW       = 2'd2;

  localparam logic [15:0] BLINK_RESET      = 16'd250;
  localparam logic [15:0] DOWN_BLINK_RESET = 16'd500;
  localparam logic [15:0] SHOW_RESET       = 16'd20;

  // Colors, 0xRRGGBB
  localparam logic [23:0] COLOR_GREEN  = 24'h008000;
  localparam logic [23:0] COLOR_RED    = 24'hFF0000;
  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_ORANGE = 24'hFFA500;
  localparam logic [23:0] COLOR_BLACK  = 24'h000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [16:0] fill_level;
    logic [2:0]  mode_code;
    logic        down_flag;
    logic [31:0] ttl_ms;
  } item_t;

  // One rendered frame: groups 1..healthy take hc, the rest dc
  typedef struct packed {
    logic [GRP_W-1:0] healthy;
    logic [23:0]      hc;
    logic [23:0]      dc;
  } frame_t;

endpackage

// File: rtl/core/lhb_core.sv
// ----------------------------------------------------------------------------
// lhb_core
// Remote display state, timers and rendering; one item per cycle unless a
// tick waits for the slot; hands the emitter a frame descriptor when due.
// ----------------------------------------------------------------------------
module lhb_core import lhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        frame_free,
  output logic        item_go,
  output logic        frame_load,
  output frame_t      frame
);

  logic [15:0] blink_period;
  logic [15:0] down_blink_period;
  logic [15:0] show_period;

  logic        remote_on, down_latched, blink_phase, down_blink_phase, frame_pending;
  logic [16:0] fill_held;
  logic [2:0]  mode_held;
  logic [31:0] expiry_time, blink_stamp, down_blink_stamp, show_stamp;

  logic        remote_on_next, down_latched_next, blink_phase_next;
  logic        down_blink_phase_next, frame_pending_next;
  logic [16:0] fill_held_next;
  logic [2:0]  mode_held_next;
  logic [31:0] expiry_time_next, blink_stamp_next, down_blink_stamp_next, show_stamp_next;

  logic        do_step;
  logic        emit;
  logic [16:0] fill_sat;
  logic [31:0] ttl_sat;
  logic [31:0] since_expiry;
  logic [24:0] healthy_sum;
  logic [8:0]  healthy_raw;
  logic [GRP_W-1:0] healthy;
  frame_t      frame_c;

  // A tick may need the descriptor slot; other kinds never do
  assign item_go = (item.kind != KIND_TICK) || frame_free;
  assign do_step = item_valid && item_go;

  always_comb begin
    remote_on_next        = remote_on;
    down_latched_next     = down_latched;
    blink_phase_next      = blink_phase;
    down_blink_phase_next = down_blink_phase;
    frame_pending_next    = frame_pending;
    fill_held_next        = fill_held;
    mode_held_next        = mode_held;
    expiry_time_next      = expiry_time;
    blink_stamp_next      = blink_stamp;
    down_blink_stamp_next = down_blink_stamp;
    show_stamp_next       = show_stamp;
    emit                  = 1'b0;
    fill_sat              = (item.fill_level > FULL_Q16) ? FULL_Q16 : item.fill_level;
    ttl_sat               = item.ttl_ms;
    if (ttl_sat == 32'd0) begin
      ttl_sat = 32'd1;
    end
    if (ttl_sat > TTL_MAX) begin
      ttl_sat = TTL_MAX;
    end
    since_expiry = item.now_ms - expiry_time;

    case (item.kind)
      KIND_SET: begin
        remote_on_next     = 1'b1;
        down_latched_next  = item.down_flag;
        fill_held_next     = fill_sat;
        mode_held_next     = item.mode_code;
        expiry_time_next   = item.now_ms + ttl_sat;
        frame_pending_next = 1'b1;
      end
      KIND_CLEAR: begin
        remote_on_next     = 1'b0;
        down_latched_next  = 1'b0;
        fill_held_next     = FULL_Q16;
        mode_held_next     = MODE_ACTIVE;
        expiry_time_next   = 32'd0;
        frame_pending_next = 1'b1;
      end
      KIND_DIRTY: begin
        frame_pending_next = 1'b1;
      end
      default: begin
        if (item.now_ms - blink_stamp >= {16'd0, blink_period}) begin
          blink_stamp_next   = item.now_ms;
          blink_phase_next   = !blink_phase;
          frame_pending_next = 1'b1;
        end
        // Expiry: down stays latched, hit flash falls back to active, else remote goes off
        if (remote_on && expiry_time != 32'd0 && !since_expiry[31]) begin
          frame_pending_next = 1'b1;
          expiry_time_next   = 32'd0;
          if (down_latched || mode_held == MODE_DOWN) begin
            expiry_time_next = 32'd0;
          end else if (mode_held == MODE_HIT) begin
            mode_held_next = MODE_ACTIVE;
          end else begin
            remote_on_next    = 1'b0;
            down_latched_next = 1'b0;
            fill_held_next    = FULL_Q16;
            mode_held_next    = MODE_ACTIVE;
          end
        end
        if (remote_on_next && mode_held_next != MODE_OFF &&
            (down_latched_next || mode_held_next == MODE_DOWN) &&
            (item.now_ms - down_blink_stamp >= {16'd0, down_blink_period})) begin
          down_blink_stamp_next = item.now_ms;
          down_blink_phase_next = !down_blink_phase;
          frame_pending_next    = 1'b1;
        end
        if (frame_pending_next && (item.now_ms - show_stamp >= {16'd0, show_period})) begin
          show_stamp_next    = item.now_ms;
          frame_pending_next = 1'b0;
          emit               = 1'b1;
        end
      end
    endcase
  end

  // Render from the state left after blink and expiry
  assign healthy_sum = 25'(fill_held_next) * 25'(GROUP_COUNT) + ROUND_Q16;
  assign healthy_raw = healthy_sum[24:16];
  assign healthy     = (healthy_raw > 9'(GROUP_COUNT)) ? GRP_W'(GROUP_COUNT)
                                                      : GRP_W'(healthy_raw);

  always_comb begin
    frame_c.healthy = healthy;
    frame_c.hc      = COLOR_GREEN;
    frame_c.dc      = COLOR_RED;
    if (!remote_on_next) begin
      frame_c.healthy = GRP_W'(GROUP_COUNT);
    end else if (mode_held_next == MODE_OFF) begin
      frame_c.healthy = '0;
      frame_c.dc      = COLOR_BLACK;
    end else if (down_latched_next || mode_held_next == MODE_DOWN) begin
      frame_c.healthy = '0;
      frame_c.dc      = down_blink_phase_next ? COLOR_RED : COLOR_BLACK;
    end else if (mode_held_next == MODE_HIT) begin
      if (blink_phase_next) begin
        frame_c.hc = COLOR_WHITE;
        frame_c.dc = COLOR_WHITE;
      end
    end else if (mode_held_next == MODE_STALE) begin
      frame_c.hc = COLOR_ORANGE;
    end
  end

  assign frame_load = do_step && emit;
  assign frame      = frame_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period      <= BLINK_RESET;
      down_blink_period <= DOWN_BLINK_RESET;
      show_period       <= SHOW_RESET;
      remote_on         <= 1'b0;
      down_latched      <= 1'b0;
      blink_phase       <= 1'b0;
      down_blink_phase  <= 1'b0;
      frame_pending     <= 1'b1;
      fill_held         <= FULL_Q16;
      mode_held         <= MODE_ACTIVE;
      expiry_time       <= 32'd0;
      blink_stamp       <= 32'd0;
      down_blink_stamp  <= 32'd0;
      show_stamp        <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLINK:      blink_period      <= cfg_data;
          CFG_DOWN_BLINK: down_blink_period <= cfg_data;
          CFG_SHOW:       show_period       <= cfg_data;
          default: ;
        endcase
      end
      if (do_step) begin
        remote_on        <= remote_on_next;
        down_latched     <= down_latched_next;
        blink_phase      <= blink_phase_next;
        down_blink_phase <= down_blink_phase_next;
        frame_pending    <= frame_pending_next;
        fill_held        <= fill_held_next;
        mode_held        <= mode_held_next;
        expiry_time      <= expiry_time_next;
        blink_stamp      <= blink_stamp_next;
        down_blink_stamp <= down_blink_stamp_next;
        show_stamp       <= show_stamp_next;
      end
    end
  end

endmodule

// File: rtl/core/lhb_emit.sv
// ----------------------------------------------------------------------------
// lhb_emit
// Frame emitter: one waiting descriptor plus the frame in flight, walked out
// one group per transfer.
// ----------------------------------------------------------------------------
module lhb_emit import lhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_load,
  input  frame_t      frame,
  output logic        frame_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  group_number,
  output logic [6:0]  led_first,
  output logic [6:0]  led_second,
  output logic [6:0]  led_third,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        frame_end
);

  logic             pend_valid;
  frame_t           pend;
  logic             cur_valid;
  frame_t           cur;
  logic [GRP_W-1:0] grp;

  logic       last;
  logic       xfer;
  logic       take_pend;
  logic [7:0] n8;
  logic [7:0] second8;
  logic [7:0] third8;
  logic [23:0] color;

  assign last      = (grp == GRP_W'(GROUP_COUNT));
  assign xfer      = cur_valid && !out_stall;
  assign take_pend = pend_valid && (!cur_valid || (xfer && last));
  assign frame_free = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
    end else begin
      if (frame_load) begin
        pend_valid <= 1'b1;
      end else if (take_pend) begin
        pend_valid <= 1'b0;
      end
      if (take_pend) begin
        cur_valid <= 1'b1;
      end else if (xfer && last) begin
        cur_valid <= 1'b0;
      end
    end
    if (frame_load) begin
      pend <= frame;
    end
    if (take_pend) begin
      cur <= pend;
      grp <= GRP_W'(1);
    end else if (xfer && !last) begin
      grp <= grp + GRP_W'(1);
    end
  end

  assign n8      = 8'(grp);
  assign second8 = 8'(2 * GROUP_COUNT) - n8;
  assign third8  = 8'(2 * GROUP_COUNT - 1) + n8;
  assign color   = (grp <= cur.healthy) ? cur.hc : cur.dc;

  assign out_valid    = cur_valid;
  assign group_number = n8[4:0];
  assign led_first    = 7'(n8 - 8'd1);
  assign led_second   = second8[6:0];
  assign led_third    = third8[6:0];
  assign red          = color[23:16];
  assign green        = color[15:8];
  assign blue         = color[7:0];
  assign frame_end    = last;

endmodule

// File: rtl/core/led_health_bar_renderer.sv
// ----------------------------------------------------------------------------
// led_health_bar_renderer
// Renders a bar of LED groups from tick and remote display items.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_stall   | kind, now_ms, fill_level, mode_code,
//           |                       | down_flag, ttl_ms
//   out     | out_valid / out_stall | group_number, led_*, red, green, blue,
//           |                       | frame_end
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// An item is registered, then updates the core state; a new item is taken
// every cycle while in_stall is low. A tick that emits a frame produces
// GROUP_COUNT results, one per cycle from the emitter while out_stall is
// low. One frame may wait behind the frame in flight; a tick finding that
// slot full holds in the input register and stalls the input.
// Reset is synchronous and leaves the bar idle with one frame pending.
// ----------------------------------------------------------------------------
module led_health_bar_renderer import lhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] now_ms,
  input  logic [16:0] fill_level,
  input  logic [2:0]  mode_code,
  input  logic        down_flag,
  input  logic [31:0] ttl_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  group_number,
  output logic [6:0]  led_first,
  output logic [6:0]  led_second,
  output logic [6:0]  led_third,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        frame_end
);

  logic   item_valid;
  item_t  item;
  logic   item_go;
  logic   frame_free;
  logic   frame_load;
  frame_t frame;

  assign in_stall = item_valid && !item_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (item_go) begin
      item_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      item <= '{kind: kind, now_ms: now_ms, fill_level: fill_level,
                mode_code: mode_code, down_flag: down_flag, ttl_ms: ttl_ms};
    end
  end

  lhb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .frame_free (frame_free),
    .item_go    (item_go),
    .frame_load (frame_load),
    .frame      (frame)
  );

  lhb_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .frame_load   (frame_load),
    .frame        (frame),
    .frame_free   (frame_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .group_number (group_number),
    .led_first    (led_first),
    .led_second   (led_second),
    .led_third    (led_third),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .frame_end    (frame_end)
  );

endmodule

// File: rtl/core/lhb_checker.sv
// ----------------------------------------------------------------------------
// lhb_checker
// Port-level checks of the LED health bar renderer, bound to the top level.
// ----------------------------------------------------------------------------
module lhb_checker import lhb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] group_number,
  input logic [6:0] led_first,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       frame_end
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(group_number) &&
      $stable(red) && $stable(green) && $stable(blue) && $stable(frame_end))
    else $error("stalled result changed");

  // Within a frame the groups follow one another
  a_group_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !frame_end |=>
      out_valid && group_number == $past(group_number) + 5'd1)
    else $error("group sequence broken inside a frame");

  // The first LED index tracks the group number
  a_led_first: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> led_first == 7'(group_number - 5'd1))
    else $error("first LED index does not match group");

  // Nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind led_health_bar_renderer lhb_checker u_lhb_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .group_number (group_number),
  .led_first    (led_first),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .frame_end    (frame_end)
);
